FILE: rtl/qte_pkg.sv
// Shared constants, types and the arctangent table for the quaternion to Euler converter.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

  localparam int QUAT_WIDTH    = 16;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  // fraction bits of the t terms, and of the CORDIC operands
  localparam int WF = 2 * QUAT_WIDTH - 4;
  localparam int GF = 28;

  localparam int PROD_W = 2 * QUAT_WIDTH;     // raw product / t sum width
  localparam int T_W    = GF + 4;             // normalized t width
  localparam int SQ_W   = 2 * GF + 2;         // square root working width
  localparam int SQRT_STEPS = GF + 1;         // one result bit per step
  localparam int C_W    = GF + 1;             // root width, at most 2^GF
  localparam int CX_W   = GF + 8;             // CORDIC x/y width with gain headroom
  localparam int NST    = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int ANG_SH = 32 - ANGLE_WIDTH;

  typedef struct packed {
    logic signed [T_W-1:0] t0;
    logic signed [T_W-1:0] t1;
    logic signed [T_W-1:0] t3;
    logic signed [T_W-1:0] t4;
    logic signed [T_W-1:0] tn;
    logic                  clamped;
  } qte_side_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/qte_if.sv
// Valid/ready channel interfaces for quaternion input and Euler angle output.
`timescale 1ns / 1ps
`default_nettype none
interface qte_quat_if import qte_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if import qte_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] roll_angle;
  logic signed [ANGLE_WIDTH-1:0] pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  logic                          pitch_clamped;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/qte_front.sv
// Products, t terms, pitch clamp and square of the pitch term: three register stages.
`timescale 1ns / 1ps
`default_nettype none
module qte_front import qte_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic signed [QUAT_WIDTH-1:0] w,
  input  wire logic signed [QUAT_WIDTH-1:0] x,
  input  wire logic signed [QUAT_WIDTH-1:0] y,
  input  wire logic signed [QUAT_WIDTH-1:0] z,
  output logic                              out_valid,
  output qte_side_t                         side,
  output logic [SQ_W-1:0]                   sq
);

  localparam int P_W  = PROD_W - 2;
  localparam int NE_W = PROD_W + GF;
  localparam logic signed [PROD_W-1:0] ONE = PROD_W'(1) << WF;

  function automatic logic signed [T_W-1:0] norm(input logic signed [PROD_W-1:0] v);
    logic signed [NE_W-1:0] e;
    e = NE_W'(v);
    if (WF >= GF) e = e >>> (WF - GF);
    else          e = e <<< (GF - WF);
    return e[T_W-1:0];
  endfunction

  function automatic logic signed [PROD_W-1:0] ext(input logic signed [P_W-1:0] v);
    return PROD_W'(v);
  endfunction

  // stage 1: products, floor shifted right by two
  logic signed [PROD_W-1:0] m_wx, m_yz, m_xx, m_yy, m_wy, m_zx, m_wz, m_xy, m_zz;
  logic signed [P_W-1:0]    p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  logic                     v1;

  assign m_wx = w * x;
  assign m_yz = y * z;
  assign m_xx = x * x;
  assign m_yy = y * y;
  assign m_wy = w * y;
  assign m_zx = z * x;
  assign m_wz = w * z;
  assign m_xy = x * y;
  assign m_zz = z * z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      p_wx <= m_wx[PROD_W-1:2];
      p_yz <= m_yz[PROD_W-1:2];
      p_xx <= m_xx[PROD_W-1:2];
      p_yy <= m_yy[PROD_W-1:2];
      p_wy <= m_wy[PROD_W-1:2];
      p_zx <= m_zx[PROD_W-1:2];
      p_wz <= m_wz[PROD_W-1:2];
      p_xy <= m_xy[PROD_W-1:2];
      p_zz <= m_zz[PROD_W-1:2];
    end
  end

  // stage 2: t terms, clamp of the pitch term
  logic signed [PROD_W-1:0] t0, t1, t2, t3, t4, t2c;
  logic                     clamp_hit;
  qte_side_t                s2;
  logic                     v2;

  always_comb begin
    t0 = (ext(p_wx) + ext(p_yz)) <<< 1;
    t1 = ONE - ((ext(p_xx) + ext(p_yy)) <<< 1);
    t2 = (ext(p_wy) - ext(p_zx)) <<< 1;
    t3 = (ext(p_wz) + ext(p_xy)) <<< 1;
    t4 = ONE - ((ext(p_yy) + ext(p_zz)) <<< 1);
    clamp_hit = 1'b1;
    if (t2 > ONE)       t2c = ONE;
    else if (t2 < -ONE) t2c = -ONE;
    else begin
      t2c = t2;
      clamp_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      s2.t0      <= norm(t0);
      s2.t1      <= norm(t1);
      s2.t3      <= norm(t3);
      s2.t4      <= norm(t4);
      s2.tn      <= norm(t2c);
      s2.clamped <= clamp_hit;
    end
  end

  // stage 3: tn squared for the cosine root
  logic signed [2*T_W-1:0] tsq;
  assign tsq = s2.tn * s2.tn;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      side <= s2;
      sq   <= tsq[SQ_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/qte_sqrt.sv
// Pipelined floor square root of 1 - tn^2, one result bit per stage, side data alongside.
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt import qte_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire qte_side_t       in_side,
  input  wire logic [SQ_W-1:0] sq,
  output logic                 out_valid,
  output qte_side_t            out_side,
  output logic [C_W-1:0]       root
);

  logic [SQ_W-1:0] rem [1:SQRT_STEPS];
  logic [SQ_W-1:0] res [1:SQRT_STEPS];
  qte_side_t       sd  [1:SQRT_STEPS];
  logic            vl  [1:SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * GF - 2 * k);
    logic [SQ_W-1:0] rem_k, res_k;
    qte_side_t       sd_k;
    logic            vl_k;
    logic [SQ_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_k = (SQ_W'(1) << (2 * GF)) - sq;
      assign res_k = '0;
      assign sd_k  = in_side;
      assign vl_k  = in_valid;
    end else begin : g_next
      assign rem_k = rem[k];
      assign res_k = res[k];
      assign sd_k  = sd[k];
      assign vl_k  = vl[k];
    end

    assign trial = res_k + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else if (en) begin
        vl[k+1] <= vl_k;
      end
      if (en) begin
        sd[k+1] <= sd_k;
        if (rem_k >= trial) begin
          rem[k+1] <= rem_k - trial;
          res[k+1] <= (res_k >> 1) + BIT;
        end else begin
          rem[k+1] <= rem_k;
          res[k+1] <= res_k >> 1;
        end
      end
    end
  end

  assign out_valid = vl[SQRT_STEPS];
  assign out_side  = sd[SQRT_STEPS];
  assign root      = res[SQRT_STEPS][C_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/qte_cordic.sv
// Vectoring CORDIC arctangent pipeline: quadrant fold stage then one stage per rotation.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic import qte_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [T_W-1:0] y,
  input  wire logic signed [T_W-1:0] x,
  output logic [31:0]                angle
);

  logic signed [CX_W-1:0] xs [0:NST];
  logic signed [CX_W-1:0] ys [0:NST];
  logic [31:0]            zs [0:NST];
  logic                   zf [0:NST];

  logic signed [CX_W-1:0] xe, ye;
  assign xe = CX_W'(x);
  assign ye = CX_W'(y);

  // fold the left half plane onto the right, offset by pi
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x == '0) && (y == '0);
      if (x < 0) begin
        xs[0] <= -xe;
        ys[0] <= -ye;
        zs[0] <= 32'h80000000;
      end else begin
        xs[0] <= xe;
        ys[0] <= ye;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_rot
    localparam logic [31:0] ATN = atan_entry(5'(i));
    logic signed [CX_W-1:0] dx, dy;
    assign dx = xs[i] >>> i;
    assign dy = ys[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + dy;
          ys[i+1] <= ys[i] - dx;
          zs[i+1] <= zs[i] + ATN;
        end else begin
          xs[i+1] <= xs[i] - dy;
          ys[i+1] <= ys[i] + dx;
          zs[i+1] <= zs[i] - ATN;
        end
      end
    end
  end

  assign angle = zf[NST] ? 32'h0 : zs[NST];

endmodule
`default_nettype wire

FILE: rtl/quaternion_to_euler_angles.sv
// Top level: quaternion in, Z-Y-X Euler angles out, fully pipelined.
//
// quat_in carries one quaternion (w, x, y, z, signed Q1.15) per word;
// euler_out carries roll, pitch, yaw (signed binary angles, full scale = pi)
// and the pitch clamp flag. Both use valid/ready; a word moves when both are high.
// One word is accepted every cycle unless the receiver stalls. A word passes
// three front stages (products, t terms, square), one square root stage per
// root bit, the CORDIC fold stage and rotations, and the output register on
// its way to euler_out. Roll and yaw operands ride along the square root
// stages so the three CORDIC pipes run side by side.
// The whole pipeline advances on one enable: it moves when the output
// register is empty or its word is being taken. When the receiver stalls with
// a word waiting, every stage holds and quat_in.ready drops; nothing is lost
// or repeated. Synchronous reset clears all valid bits; payload is left as is.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles import qte_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  qte_quat_if.sink    quat_in,
  qte_euler_if.source euler_out
);

  localparam logic [31:0] HALF = (ANG_SH > 0) ? (32'd1 << ANG_SH) >> 1 : 32'd0;
  localparam logic signed [31:0] PMAX = 32'sd1 <<< 30;

  logic en;
  assign en = !euler_out.valid || euler_out.ready;
  assign quat_in.ready = en;

  logic            f_valid;
  qte_side_t       f_side;
  logic [SQ_W-1:0] f_sq;

  qte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (quat_in.valid),
    .w         (quat_in.quat_w),
    .x         (quat_in.quat_x),
    .y         (quat_in.quat_y),
    .z         (quat_in.quat_z),
    .out_valid (f_valid),
    .side      (f_side),
    .sq        (f_sq)
  );

  logic           s_valid;
  qte_side_t      s_side;
  logic [C_W-1:0] s_root;

  qte_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .sq        (f_sq),
    .out_valid (s_valid),
    .out_side  (s_side),
    .root      (s_root)
  );

  logic [31:0] roll_z, pitch_z, yaw_z;

  qte_cordic u_roll (
    .clk   (clk),
    .en    (en),
    .y     (s_side.t0),
    .x     (s_side.t1),
    .angle (roll_z)
  );

  qte_cordic u_pitch (
    .clk   (clk),
    .en    (en),
    .y     (s_side.tn),
    .x     (T_W'(s_root)),
    .angle (pitch_z)
  );

  qte_cordic u_yaw (
    .clk   (clk),
    .en    (en),
    .y     (s_side.t3),
    .x     (s_side.t4),
    .angle (yaw_z)
  );

  // valid and clamp flag alongside the CORDIC stages
  logic [NST:0] cv;
  logic [NST:0] cf;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= '0;
    end else if (en) begin
      cv <= {cv[NST-1:0], s_valid};
    end
    if (en) begin
      cf <= {cf[NST-1:0], s_side.clamped};
    end
  end

  logic signed [31:0] ps;
  logic [31:0]        pitch_l, roll_r, pitch_r, yaw_r;

  always_comb begin
    ps = signed'(pitch_z);
    if (ps > PMAX)       pitch_l = PMAX;
    else if (ps < -PMAX) pitch_l = -PMAX;
    else                 pitch_l = pitch_z;
    roll_r  = roll_z + HALF;
    pitch_r = pitch_l + HALF;
    yaw_r   = yaw_z + HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      euler_out.valid <= 1'b0;
    end else if (en) begin
      euler_out.valid <= cv[NST];
    end
    if (en) begin
      euler_out.roll_angle    <= roll_r[31:ANG_SH];
      euler_out.pitch_angle   <= pitch_r[31:ANG_SH];
      euler_out.yaw_angle     <= yaw_r[31:ANG_SH];
      euler_out.pitch_clamped <= cf[NST];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/qte_checker.sv
// Port-level checks on the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qte_checker import qte_pkg::*; (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [ANGLE_WIDTH-1:0] pitch_angle
);

  localparam logic signed [ANGLE_WIDTH-1:0] QUARTER =
    ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side can move");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result word dropped");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= QUARTER) && (pitch_angle >= -QUARTER))
    else $error("pitch beyond a quarter turn");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (quat_in.ready),
  .out_valid   (euler_out.valid),
  .out_ready   (euler_out.ready),
  .pitch_angle (euler_out.pitch_angle)
);
`default_nettype wire
